[hdl/radial_distortion_with_inverse_fit_unit_defines.svh]
// assertion macros shared by the checker of the radial distortion unit
`ifndef RADIAL_DISTORTION_WITH_INVERSE_FIT_UNIT_DEFINES_SVH
`define RADIAL_DISTORTION_WITH_INVERSE_FIT_UNIT_DEFINES_SVH

// same-cycle implication
`define RDI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rdi_pkg.sv]
// shared types, constants and helpers of the radial distortion unit
package rdi_pkg;

  localparam int SAMPLE_COUNT = 10;
  localparam int SmpW         = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int RemW         = $clog2(SAMPLE_COUNT) + 1;
  localparam int SampleStep   = 16384 / SAMPLE_COUNT;
  localparam int SampleRem    = 16384 % SAMPLE_COUNT;

  localparam int CoefW   = 16;
  localparam int RadW    = 16;
  localparam int CfgIdxW = 2;
  localparam int OpW     = 34;
  localparam int ProdW   = 2 * OpW;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegK1 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegK2 = 2'd1;

  // operand pair of the shared multiplier
  typedef struct packed {
    logic signed [OpW-1:0] a;
    logic signed [OpW-1:0] b;
  } mul_op_t;

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? 64'(n) : 64'(v);
  endfunction

  // signed operand from sign and a magnitude below 2^31
  function automatic logic signed [OpW-1:0] op_sm(input logic sgn, input logic [63:0] m);
    logic signed [OpW-1:0] p;
    p = {2'b00, m[31:0]};
    return sgn ? -p : p;
  endfunction

endpackage

[hdl/rdi_ifs.sv]
// request channels of the radial distortion unit
interface rdi_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [rdi_pkg::RadW-1:0] radius_in;
  modport source (output valid, output command, output radius_in, input ready);
  modport sink (input valid, input command, input radius_in, output ready);
endinterface

interface rdi_out_if;
  logic                             valid;
  logic                             ready;
  logic [rdi_pkg::RadW-1:0]         radius_out;
  logic signed [rdi_pkg::CoefW-1:0] inverse_k1;
  logic signed [rdi_pkg::CoefW-1:0] inverse_k2;
  logic                             fit_singular;
  modport source (output valid, output radius_out, output inverse_k1, output inverse_k2,
                  output fit_singular, input ready);
  modport sink (input valid, input radius_out, input inverse_k1, input inverse_k2,
                input fit_singular, output ready);
endinterface

[hdl/rdi_mul.sv]
// shared signed multiplier with registered product
module rdi_mul (
  input  logic                                clk_i,
  input  rdi_pkg::mul_op_t                    op_i,
  output logic signed [rdi_pkg::ProdW-1:0]    prod_o
);
  import rdi_pkg::*;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    prod_o <= op_i.a * op_i.b;
  end

endmodule

[hdl/radial_distortion_with_inverse_fit_unit.sv]
// top level of the radial distortion unit with inverse coefficient fit
// A request runs through the polynomial states P0..P7 on one shared 34x34 multiplier, and
// the next request is taken once the unit is back in idle; the unit takes no new request
// meanwhile. The first request after reset or after a coefficient write first runs the
// inverse fit: the polynomial and the power states per sample radius (SAMPLE_COUNT samples),
// a summing state, operand scaling, determinant states D0..D6 and, when the determinant is
// nonzero, two bit-serial divisions (76 steps and a finishing state each). A finished result
// waits in the output register while the next request is taken; the polynomial's last step
// holds until the output register is free.
module radial_distortion_with_inverse_fit_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rdi_in_if.sink                        in_if,
  rdi_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [rdi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rdi_pkg::CoefW-1:0]     cfg_data_i
);
  import rdi_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_P0     = 5'd1;
  localparam logic [4:0] S_P1     = 5'd2;
  localparam logic [4:0] S_P2     = 5'd3;
  localparam logic [4:0] S_P3     = 5'd4;
  localparam logic [4:0] S_P4     = 5'd5;
  localparam logic [4:0] S_P5     = 5'd6;
  localparam logic [4:0] S_P6     = 5'd7;
  localparam logic [4:0] S_P7     = 5'd8;
  localparam logic [4:0] S_FPWA   = 5'd9;
  localparam logic [4:0] S_FPWB   = 5'd10;
  localparam logic [4:0] S_FPWC   = 5'd11;
  localparam logic [4:0] S_FSUM   = 5'd12;
  localparam logic [4:0] S_FSHIFT = 5'd13;
  localparam logic [4:0] S_D0     = 5'd14;
  localparam logic [4:0] S_D1     = 5'd15;
  localparam logic [4:0] S_D2     = 5'd16;
  localparam logic [4:0] S_D3     = 5'd17;
  localparam logic [4:0] S_D4     = 5'd18;
  localparam logic [4:0] S_D5     = 5'd19;
  localparam logic [4:0] S_D6     = 5'd20;
  localparam logic [4:0] S_DIV    = 5'd21;
  localparam logic [4:0] S_DIVEND = 5'd22;

  localparam logic [6:0] DivLast  = 7'd75;
  localparam logic [6:0] DivBits  = 7'd64;

  // handshake views
  logic in_valid, in_ready, in_acc, out_valid, out_ready, out_free;
  logic [RadW-1:0]         out_radius;
  logic signed [CoefW-1:0] out_k1, out_k2;
  logic                    out_singular;

  // control state
  logic [4:0]              state_q, state_d;
  logic signed [CoefW-1:0] k1_q, k2_q, inv1_q, inv2_q;
  logic                    fit_done_q, sing_q, out_valid_q, item_q, cross_q, cmd_q, dsel_q;
  logic [3:0]              n_q;
  logic [SmpW-1:0]         smp_q;
  logic [6:0]              dcnt_q;

  // datapath
  logic [RadW-1:0]         rad_q, pr_r_q, x_q, out_q, rout_q;
  logic [RemW-1:0]         orem_q;
  logic [17:0]             r2_q;
  logic [21:0]             r4_q;
  logic signed [63:0]      acc_q, det_q, det1_q, det2_q;
  logic [47:0]             pw_q;
  logic [63:0]             s4_q, s6_q, s8_q, s10_q, s3d_q, s5d_q;
  logic [63:0]             ma_q, mb_q, mc_q, mv1_q, mv2_q;
  logic                    sv1_q, sv2_q;
  logic [63:0]             dvd_q, md_q, rem_q;
  logic [16:0]             q_q;
  logic                    ovf_q, dneg_q;
  logic signed [CoefW-1:0] oinv1_q, oinv2_q;
  logic                    osing_q;

  // shared multiplier
  mul_op_t                 mul_op;
  logic signed [ProdW-1:0] prod_q;
  logic signed [63:0]      prod64, sum_w, dif_w, rnd_w, v1_w, v2_w;
  logic [37:0]             rsh_w;
  logic [RadW-1:0]         poly_res, mult;
  logic signed [CoefW-1:0] pk1, pk2, divres;
  logic [63:0]             val_w;
  logic [RemW-1:0]         orem_sum, orem_nx;
  logic                    wrap, big, last_smp, dbit, ge;
  logic [RadW-1:0]         out_nx;
  logic [64:0]             rn_w;
  logic [63:0]             rem_nx;

  rdi_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod_q)
  );

  // port views
  assign in_valid  = in_if.valid;
  assign in_ready  = (state_q == S_IDLE);
  assign in_if.ready = in_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_ready = out_if.ready;
  assign out_valid = out_valid_q;
  assign out_free  = !out_valid_q || out_ready;
  assign out_radius   = rout_q;
  assign out_k1       = oinv1_q;
  assign out_k2       = oinv2_q;
  assign out_singular = osing_q;
  assign out_if.valid        = out_valid;
  assign out_if.radius_out   = out_radius;
  assign out_if.inverse_k1   = out_k1;
  assign out_if.inverse_k2   = out_k2;
  assign out_if.fit_singular = out_singular;

  // coefficient and multiplicand selection
  assign pk1  = (item_q && cmd_q) ? inv1_q : k1_q;
  assign pk2  = (item_q && cmd_q) ? inv2_q : k2_q;
  assign mult = cross_q ? out_q : x_q;

  // adder, rounding and saturation of the polynomial
  assign prod64 = prod_q[63:0];
  assign sum_w  = acc_q + prod64;
  assign dif_w  = acc_q - prod64;
  assign rnd_w  = sum_w + 64'sd33554432;
  assign rsh_w  = rnd_w[63:26];
  always_comb begin
    if (sum_w[63]) begin
      poly_res = '0;
    end else if (|rsh_w[37:16]) begin
      poly_res = '1;
    end else begin
      poly_res = rsh_w[15:0];
    end
  end
  assign val_w = {14'd0, sum_w[63:14]};

  // next sample radius
  assign orem_sum = orem_q + RemW'(SampleRem);
  assign wrap     = (orem_sum >= RemW'(SAMPLE_COUNT));
  assign orem_nx  = wrap ? (orem_sum - RemW'(SAMPLE_COUNT)) : orem_sum;
  assign out_nx   = out_q + RadW'(SampleStep) + {{(RadW-1){1'b0}}, wrap};
  assign last_smp = (smp_q == SmpW'(SAMPLE_COUNT - 1));

  // normal equation operands
  assign v1_w = s3d_q - s4_q;
  assign v2_w = s5d_q - s6_q;
  assign big  = (|ma_q[63:31]) || (|mb_q[63:31]) || (|mc_q[63:31]) ||
                (|mv1_q[63:31]) || (|mv2_q[63:31]);

  // restoring division step
  assign dbit   = (dcnt_q < DivBits) ? dvd_q[63] : 1'b0;
  assign rn_w   = {rem_q, dbit};
  assign ge     = (rn_w >= {1'b0, md_q});
  assign rem_nx = ge ? 64'(rn_w - {1'b0, md_q}) : rn_w[63:0];
  always_comb begin
    if (dneg_q) begin
      divres = (ovf_q || q_q > 17'd32768) ? -16'sd32768 : CoefW'(~q_q[15:0] + 16'd1);
    end else begin
      divres = (ovf_q || q_q > 17'd32767) ? 16'sd32767 : CoefW'(q_q[15:0]);
    end
  end

  // sequencer and multiplier operands
  always_comb begin
    state_d = state_q;
    mul_op  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_P0;
        end
      end
      S_P0: begin
        mul_op.a = {18'd0, pr_r_q};
        mul_op.b = {18'd0, pr_r_q};
        state_d  = S_P1;
      end
      S_P1: begin
        mul_op.a = {16'd0, prod_q[31:14]};
        mul_op.b = {16'd0, prod_q[31:14]};
        state_d  = S_P2;
      end
      S_P2: begin
        mul_op.a = {{18{pk1[15]}}, pk1};
        mul_op.b = {16'd0, r2_q};
        state_d  = S_P3;
      end
      S_P3: begin
        mul_op.a = {{18{pk2[15]}}, pk2};
        mul_op.b = {12'd0, r4_q};
        state_d  = S_P4;
      end
      S_P4: state_d = S_P5;
      S_P5: begin
        mul_op.a = acc_q[49:16];
        mul_op.b = {18'd0, pr_r_q};
        state_d  = S_P6;
      end
      S_P6: begin
        mul_op.a = {18'd0, acc_q[15:0]};
        mul_op.b = {18'd0, pr_r_q};
        state_d  = S_P7;
      end
      S_P7: begin
        if (!item_q) begin
          state_d = S_FPWA;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_FPWA: begin
        mul_op.a = {10'd0, pw_q[47:24]};
        mul_op.b = {18'd0, mult};
        state_d  = S_FPWB;
      end
      S_FPWB: begin
        mul_op.a = {10'd0, pw_q[23:0]};
        mul_op.b = {18'd0, mult};
        state_d  = S_FPWC;
      end
      S_FPWC: begin
        if (!cross_q && n_q == 4'd10) begin
          state_d = last_smp ? S_FSUM : S_P0;
        end else begin
          state_d = S_FPWA;
        end
      end
      S_FSUM: state_d = S_FSHIFT;
      S_FSHIFT: begin
        if (!big) begin
          state_d = S_D0;
        end
      end
      S_D0: begin
        mul_op.a = op_sm(1'b0, ma_q);
        mul_op.b = op_sm(1'b0, mc_q);
        state_d  = S_D1;
      end
      S_D1: begin
        mul_op.a = op_sm(1'b0, mb_q);
        mul_op.b = op_sm(1'b0, mb_q);
        state_d  = S_D2;
      end
      S_D2: begin
        mul_op.a = op_sm(sv1_q, mv1_q);
        mul_op.b = op_sm(1'b0, mc_q);
        state_d  = S_D3;
      end
      S_D3: begin
        mul_op.a = op_sm(1'b0, mb_q);
        mul_op.b = op_sm(sv2_q, mv2_q);
        state_d  = S_D4;
      end
      S_D4: begin
        mul_op.a = op_sm(1'b0, ma_q);
        mul_op.b = op_sm(sv2_q, mv2_q);
        state_d  = S_D5;
      end
      S_D5: begin
        mul_op.a = op_sm(sv1_q, mv1_q);
        mul_op.b = op_sm(1'b0, mb_q);
        state_d  = S_D6;
      end
      S_D6: state_d = (det_q == 64'sd0) ? S_P0 : S_DIV;
      S_DIV: begin
        if (dcnt_q == DivLast) begin
          state_d = S_DIVEND;
        end
      end
      S_DIVEND: state_d = dsel_q ? S_P0 : S_DIV;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k1_q        <= '0;
      k2_q        <= '0;
      inv1_q      <= '0;
      inv2_q      <= '0;
      fit_done_q  <= 1'b0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      item_q      <= 1'b0;
      cross_q     <= 1'b0;
      cmd_q       <= 1'b0;
      dsel_q      <= 1'b0;
      n_q         <= '0;
      smp_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      // coefficient writes restart the fit
      if (cfg_we_i && cfg_idx_i == RegK1) begin
        k1_q       <= cfg_data_i;
        fit_done_q <= 1'b0;
      end else if (cfg_we_i && cfg_idx_i == RegK2) begin
        k2_q       <= cfg_data_i;
        fit_done_q <= 1'b0;
      end
      // result register handshake
      if (state_q == S_P7 && item_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q  <= in_if.command;
            item_q <= fit_done_q;
            smp_q  <= '0;
          end
        end
        S_P7: begin
          if (!item_q) begin
            n_q     <= 4'd2;
            cross_q <= 1'b0;
          end
        end
        S_FPWC: begin
          if (cross_q) begin
            cross_q <= 1'b0;
            n_q     <= n_q + 4'd1;
          end else if (n_q == 4'd3 || n_q == 4'd5) begin
            cross_q <= 1'b1;
          end else if (n_q == 4'd10) begin
            if (!last_smp) begin
              smp_q <= smp_q + SmpW'(1);
            end
          end else begin
            n_q <= n_q + 4'd1;
          end
        end
        S_D6: begin
          if (det_q == 64'sd0) begin
            inv1_q     <= '0;
            inv2_q     <= '0;
            sing_q     <= 1'b1;
            fit_done_q <= 1'b1;
            item_q     <= 1'b1;
          end else begin
            dsel_q <= 1'b0;
            dcnt_q <= '0;
          end
        end
        S_DIV: dcnt_q <= dcnt_q + 7'd1;
        S_DIVEND: begin
          if (!dsel_q) begin
            inv1_q <= divres;
            dsel_q <= 1'b1;
            dcnt_q <= '0;
          end else begin
            inv2_q     <= divres;
            sing_q     <= 1'b0;
            fit_done_q <= 1'b1;
            item_q     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rad_q  <= in_if.radius_in;
          pr_r_q <= fit_done_q ? in_if.radius_in : RadW'(SampleStep);
          out_q  <= RadW'(SampleStep);
          orem_q <= RemW'(SampleRem);
          s4_q   <= '0;
          s6_q   <= '0;
          s8_q   <= '0;
          s10_q  <= '0;
          s3d_q  <= '0;
          s5d_q  <= '0;
        end
      end
      S_P1: r2_q <= prod_q[31:14];
      S_P2: r4_q <= prod_q[35:14];
      S_P3: acc_q <= 64'sd67108864 + prod64;
      S_P4: acc_q <= sum_w;
      S_P6: acc_q <= prod64 <<< 16;
      S_P7: begin
        if (item_q && out_free) begin
          rout_q  <= poly_res;
          oinv1_q <= inv1_q;
          oinv2_q <= inv2_q;
          osing_q <= sing_q;
        end else if (!item_q) begin
          x_q  <= poly_res;
          pw_q <= {22'd0, poly_res, 10'd0};
        end else begin
          // keep the full product while the result register is busy
          acc_q <= sum_w;
        end
      end
      S_FPWB: acc_q <= prod64 <<< 24;
      S_FPWC: begin
        if (cross_q) begin
          if (n_q == 4'd3) begin
            s3d_q <= s3d_q + val_w;
          end else begin
            s5d_q <= s5d_q + val_w;
          end
        end else begin
          pw_q <= val_w[47:0];
          case (n_q)
            4'd4:    s4_q  <= s4_q + val_w;
            4'd6:    s6_q  <= s6_q + val_w;
            4'd8:    s8_q  <= s8_q + val_w;
            4'd10:   s10_q <= s10_q + val_w;
            default: ;
          endcase
          if (n_q == 4'd10 && !last_smp) begin
            out_q  <= out_nx;
            orem_q <= orem_nx;
            pr_r_q <= out_nx;
          end
        end
      end
      S_FSUM: begin
        ma_q  <= s6_q;
        mb_q  <= s8_q;
        mc_q  <= s10_q;
        sv1_q <= v1_w[63];
        mv1_q <= mag64(v1_w);
        sv2_q <= v2_w[63];
        mv2_q <= mag64(v2_w);
      end
      S_FSHIFT: begin
        if (big) begin
          ma_q  <= ma_q >> 1;
          mb_q  <= mb_q >> 1;
          mc_q  <= mc_q >> 1;
          mv1_q <= mv1_q >> 1;
          mv2_q <= mv2_q >> 1;
        end
      end
      S_D1: acc_q <= prod64;
      S_D2: det_q <= dif_w;
      S_D3: acc_q <= prod64;
      S_D4: det1_q <= dif_w;
      S_D5: acc_q <= prod64;
      S_D6: begin
        det2_q <= dif_w;
        pr_r_q <= rad_q;
        dvd_q  <= mag64(det1_q);
        md_q   <= mag64(det_q);
        dneg_q <= det1_q[63] ^ det_q[63];
        rem_q  <= '0;
        q_q    <= '0;
        ovf_q  <= 1'b0;
      end
      S_DIV: begin
        dvd_q <= dvd_q << 1;
        rem_q <= rem_nx;
        q_q   <= {q_q[15:0], ge};
        ovf_q <= ovf_q | q_q[16];
      end
      S_DIVEND: begin
        pr_r_q <= rad_q;
        dvd_q  <= mag64(det2_q);
        dneg_q <= det2_q[63] ^ det_q[63];
        rem_q  <= '0;
        q_q    <= '0;
        ovf_q  <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

[hdl/rdi_chk.sv]
// port checker of the radial distortion unit and its bind
`include "radial_distortion_with_inverse_fit_unit_defines.svh"

module rdi_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rdi_pkg::RadW-1:0]      radius_out_i,
  input logic [rdi_pkg::CoefW-1:0]     inverse_k1_i,
  input logic [rdi_pkg::CoefW-1:0]     inverse_k2_i,
  input logic                          fit_singular_i
);
  import rdi_pkg::*;

  // the unit is busy right after taking a request
  `RDI_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready after request")
  // a singular fit reports zero coefficients
  `RDI_ASSERT_IMP(a_sing_zero, clk_i, rst_ni, out_valid_i && fit_singular_i, inverse_k1_i == '0 && inverse_k2_i == '0, "singular fit with nonzero coefficients")
  // a new result only comes out of a busy cycle
  `RDI_ASSERT_IMP(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i), "result without work")
  // a stalled result holds
  `RDI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(radius_out_i), "stalled result changed")

endmodule

bind radial_distortion_with_inverse_fit_unit rdi_chk u_rdi_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid),
  .in_ready_i     (in_ready),
  .out_valid_i    (out_valid),
  .out_ready_i    (out_ready),
  .radius_out_i   (out_radius),
  .inverse_k1_i   (out_k1),
  .inverse_k2_i   (out_k2),
  .fit_singular_i (out_singular)
);

[tb/tb_top.sv]
// self-checking testbench of the radial distortion unit with inverse coefficient fit
`timescale 1ns / 100ps

module tb_top;
  import rdi_pkg::*;

  localparam int CycleLimit = 400000;

  // one expected distortion result
  typedef struct {
    logic [RadW-1:0]         radius;
    logic signed [CoefW-1:0] inv_k1;
    logic signed [CoefW-1:0] inv_k2;
    logic                    singular;
  } dist_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CoefW-1:0] cfg_data;

  rdi_in_if  req_ch ();
  rdi_out_if res_ch ();

  radial_distortion_with_inverse_fit_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (req_ch),
    .out_if     (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // mirror of the unit's coefficients and fit state
  logic signed [CoefW-1:0] fwd_k1, fwd_k2, inv_k1, inv_k2;
  logic fit_valid, fit_singular;

  dist_result_t pending_results[$];
  int errors;
  int cycles;
  int hold_cycles;
  bit idle_on;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // r * (1 + k1*r^2 + k2*r^4) in Q2.14, rounded half up and clamped
  function automatic logic [RadW-1:0] distort_radius(input logic [RadW-1:0] r,
                                                     input logic signed [CoefW-1:0] k1,
                                                     input logic signed [CoefW-1:0] k2);
    longint r2, r4, fac, prod, res;
    r2   = (longint'(r) * longint'(r)) >>> 14;
    r4   = (r2 * r2) >>> 14;
    fac  = (longint'(1) <<< 26) + longint'(k1) * r2 + longint'(k2) * r4;
    prod = fac * longint'(r);
    if (prod < 0) return '0;
    res = (prod + (longint'(1) <<< 25)) >>> 26;
    return (res > 65535) ? 16'hFFFF : res[RadW-1:0];
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // magnitude shift that truncates toward zero
  function automatic longint shift_toward_zero(input longint v, input int sh);
    longint unsigned m;
    m = abs64(v) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // num/den in Q4.12 truncated toward zero, saturated
  function automatic logic signed [CoefW-1:0] quotient_q12(input longint num, input longint den);
    bit neg;
    longint unsigned mn, md, q, rem, res;
    neg = (num < 0) != (den < 0);
    mn  = abs64(num);
    md  = abs64(den);
    q   = mn / md;
    rem = mn % md;
    if (q > 8) return neg ? -16'sd32768 : 16'sd32767;
    res = q;
    for (int i = 0; i < 12; i++) begin
      rem = rem << 1;
      res = res << 1;
      if (rem >= md) begin
        rem = rem - md;
        res = res | 1;
      end
    end
    if (neg) return (res > 32768) ? -16'sd32768 : -res[CoefW-1:0];
    return (res > 32767) ? 16'sd32767 : res[CoefW-1:0];
  endfunction

  // least-squares fit of the inverse coefficients from the forward ones
  task automatic fit_inverse();
    longint unsigned s4, s6, s8, s10, s3d, s5d, mx, smp, x;
    longint unsigned pw[11];
    longint a, b, c, v1, v2, det, det1, det2;
    int sh;
    s4 = 0; s6 = 0; s8 = 0; s10 = 0; s3d = 0; s5d = 0; sh = 0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      smp   = longint'(i + 1) * 16384 / SAMPLE_COUNT;
      x     = distort_radius(smp[RadW-1:0], fwd_k1, fwd_k2);
      pw[1] = x << 10;
      for (int n = 2; n <= 10; n++) pw[n] = (pw[n-1] * x) >> 14;
      s4  += pw[4];
      s6  += pw[6];
      s8  += pw[8];
      s10 += pw[10];
      s3d += (pw[3] * smp) >> 14;
      s5d += (pw[5] * smp) >> 14;
    end
    a  = s6;
    b  = s8;
    c  = s10;
    v1 = longint'(s3d) - longint'(s4);
    v2 = longint'(s5d) - longint'(s6);
    mx = s6;
    if (s8 > mx) mx = s8;
    if (s10 > mx) mx = s10;
    if (abs64(v1) > mx) mx = abs64(v1);
    if (abs64(v2) > mx) mx = abs64(v2);
    while ((mx >> sh) >= (64'd1 << 31)) sh++;
    a  = shift_toward_zero(a, sh);
    b  = shift_toward_zero(b, sh);
    c  = shift_toward_zero(c, sh);
    v1 = shift_toward_zero(v1, sh);
    v2 = shift_toward_zero(v2, sh);
    det = a * c - b * b;
    if (det == 0) begin
      inv_k1       = '0;
      inv_k2       = '0;
      fit_singular = 1'b1;
    end else begin
      det1         = v1 * c - b * v2;
      det2         = a * v2 - v1 * b;
      inv_k1       = quotient_q12(det1, det);
      inv_k2       = quotient_q12(det2, det);
      fit_singular = 1'b0;
    end
    fit_valid = 1'b1;
  endtask

  // expected result of one accepted request
  task automatic predict_distortion(input logic cmd, input logic [RadW-1:0] r);
    dist_result_t e;
    if (!fit_valid) fit_inverse();
    e.radius   = cmd ? distort_radius(r, inv_k1, inv_k2) : distort_radius(r, fwd_k1, fwd_k2);
    e.inv_k1   = inv_k1;
    e.inv_k2   = inv_k2;
    e.singular = fit_singular;
    pending_results.push_back(e);
  endtask

  // send one request; called at a rising edge
  task automatic send_request(input logic cmd, input logic [RadW-1:0] r);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.radius_in <= r;
    do @(posedge clk); while (!req_ch.ready);
    predict_distortion(cmd, r);
  endtask

  task automatic stop_requests();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected result has come back
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only while the unit is idle
  task automatic write_coef(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegK1) begin
      fwd_k1    = value;
      fit_valid = 1'b0;
    end else if (idx == RegK2) begin
      fwd_k2    = value;
      fit_valid = 1'b0;
    end
    @(posedge clk);
  endtask

  function automatic logic [RadW-1:0] rand_radius();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 16384)) : 16'($urandom);
  endfunction

  // power-on coefficients and radius extremes
  task automatic test_power_on();
    send_request(1'b0, 16'h0000);
    send_request(1'b1, 16'h0000);
    send_request(1'b0, 16'hFFFF);
    send_request(1'b1, 16'hFFFF);
    send_request(1'b0, 16'h4000);
    send_request(1'b1, 16'h4000);
    stop_requests();
    drain();
  endtask

  // coefficient extremes: output saturation high and low, ignored register indexes
  task automatic test_coef_extremes();
    write_coef(RegK1, 16'h7FFF);
    write_coef(RegK2, 16'h7FFF);
    send_request(1'b0, 16'hFFFF);
    send_request(1'b1, 16'hFFFF);
    send_request(1'b0, 16'h0001);
    send_request(1'b1, 16'h8000);
    stop_requests();
    drain();
    write_coef(RegK1, 16'h8000);
    write_coef(RegK2, 16'h8000);
    send_request(1'b0, 16'hFFFF);
    send_request(1'b1, 16'hFFFF);
    send_request(1'b0, 16'h2000);
    send_request(1'b1, 16'h4000);
    stop_requests();
    drain();
    // writes to unused indexes must not trigger a refit
    write_coef(2'd2, 16'($urandom));
    write_coef(2'd3, 16'($urandom));
    send_request(1'b1, 16'h3000);
    send_request(1'b0, 16'hC000);
    stop_requests();
    drain();
  endtask

  // random coefficient phases with random radii
  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph % 4) != 3;
      if ($urandom_range(0, 2) == 0) begin
        write_coef(RegK1, 16'($urandom));
        write_coef(RegK2, 16'($urandom));
      end else begin
        write_coef(RegK1, 16'($signed($urandom_range(0, 8192)) - 4096));
        write_coef(RegK2, 16'($signed($urandom_range(0, 4096)) - 2048));
      end
      for (int i = 0; i < 45; i++) send_request(1'($urandom), rand_radius());
      stop_requests();
      drain();
    end
    idle_on = 1'b1;
  endtask

  // long output stall while requests keep coming
  task automatic test_backpressure();
    write_coef(RegK1, 16'hF000);
    hold_cycles = 300;
    idle_on     = 1'b0;
    for (int i = 0; i < 25; i++) send_request(1'($urandom), rand_radius());
    stop_requests();
    idle_on = 1'b1;
    drain();
  endtask

  // output side: random stalls and the long hold-off
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    dist_result_t e;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result radius=%h", res_ch.radius_out);
      end else begin
        e = pending_results.pop_front();
        if (res_ch.radius_out !== e.radius || res_ch.inverse_k1 !== e.inv_k1 ||
            res_ch.inverse_k2 !== e.inv_k2 || res_ch.fit_singular !== e.singular) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp r=%h k1=%h k2=%h s=%b  got r=%h k1=%h k2=%h s=%b",
                     e.radius, e.inv_k1, e.inv_k2, e.singular, res_ch.radius_out,
                     res_ch.inverse_k1, res_ch.inverse_k2, res_ch.fit_singular);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // test sequence
  initial begin
    errors       = 0;
    cycles       = 0;
    hold_cycles  = 0;
    idle_on      = 1'b1;
    fwd_k1       = '0;
    fwd_k2       = '0;
    inv_k1       = '0;
    inv_k2       = '0;
    fit_valid    = 1'b0;
    fit_singular = 1'b0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.command   <= 1'b0;
    req_ch.radius_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on();
    test_coef_extremes();
    test_random_phases();
    test_backpressure();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
